// ===== rtl/rbld_pkg.sv =====
// ----------------------------------------------------------------------------
// rbld_pkg
// Types, widths and the face color table shared by the breathing LED driver.
// ----------------------------------------------------------------------------
package rbld_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned LIN_W      = 8;   // triangle level, up to the peak
  localparam int unsigned PHASE_W    = 9;   // phase runs 0 .. 2*peak-1
  localparam int unsigned SQ_W       = 16;  // lin squared
  localparam int unsigned REG_W      = 16;  // config register width
  localparam int unsigned DIV_NUM_W  = 32;
  localparam int unsigned DIV_DEN_W  = 16;
  localparam int unsigned NUM_LANES  = 3;

  // register index, taken from paddr[2]
  localparam logic REG_SPEED_DIVIDER  = 1'b0;
  localparam logic REG_MAX_BRIGHTNESS = 1'b1;

  localparam logic [REG_W-1:0] SPEED_DIVIDER_RST  = 16'd1;
  localparam logic [REG_W-1:0] MAX_BRIGHTNESS_RST = 16'd255;

  localparam logic [3:0] NUM_FACES = 4'd10;

  typedef struct packed {
    logic       playing;
    logic [3:0] face_code;
  } rbld_in_t;

  typedef struct packed {
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
  } rbld_out_t;

  // one queued job: either an all-black result or a fade computation
  typedef struct packed {
    logic             black;
    logic [LIN_W-1:0] lin;
    logic [3:0]       face;
  } rbld_job_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_SCALE,
    S_FACT_LO,
    S_FACT_HI,
    S_CH_START,
    S_CH_DIV,
    S_DONE
  } rbld_state_e;

  // base color {red, green, blue}; unknown faces are black
  function automatic logic [23:0] base_color(input logic [3:0] face);
    logic [23:0] rgb;
    case (face)
      4'd0:    rgb = {8'd255, 8'd200, 8'd0};
      4'd1:    rgb = {8'd50,  8'd255, 8'd50};
      4'd2:    rgb = {8'd0,   8'd200, 8'd200};
      4'd3:    rgb = {8'd255, 8'd255, 8'd255};
      4'd4:    rgb = {8'd100, 8'd100, 8'd100};
      4'd5:    rgb = {8'd60,  8'd60,  8'd80};
      4'd6:    rgb = {8'd255, 8'd0,   8'd0};
      4'd7:    rgb = {8'd0,   8'd0,   8'd255};
      4'd8:    rgb = {8'd40,  8'd0,   8'd80};
      4'd9:    rgb = {8'd255, 8'd150, 8'd0};
      default: rgb = 24'd0;
    endcase
    return rgb;
  endfunction

endpackage

// ===== rtl/rbld_front.sv =====
// ----------------------------------------------------------------------------
// rbld_front
// Takes ticks, keeps the running mark, prescaler and phase, and queues a job
// for every tick that produces a result.
// ----------------------------------------------------------------------------
module rbld_front #(
  parameter int unsigned PEAK_LEVEL = 255
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  rbld_pkg::rbld_in_t         in_data_i,
  input  logic [rbld_pkg::REG_W-1:0] speed_divider_i,
  input  logic                       q_full_i,
  output logic                       in_stall_o,
  output logic                       push_o,
  output rbld_pkg::rbld_job_t        job_o
);
  import rbld_pkg::*;

  localparam logic [PHASE_W-1:0] PEAK_PH  = PHASE_W'(PEAK_LEVEL);
  localparam logic [PHASE_W-1:0] PEAK2_PH = PHASE_W'(2 * PEAK_LEVEL);

  logic [REG_W-1:0]   pre_q, pre_d, pre_inc;
  logic [PHASE_W-1:0] phase_q, phase_d, phase_inc, phase_dn;
  logic               run_q, run_d;
  logic               accept, run_eff, pass, wrap;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;

  always_comb begin
    run_eff   = run_q | in_data_i.playing;
    pre_inc   = pre_q + 16'd1;
    pass      = pre_inc >= speed_divider_i;
    phase_inc = phase_q + 9'd1;
    wrap      = phase_inc >= PEAK2_PH;
    phase_dn  = PEAK2_PH - phase_q;

    pre_d      = pre_q;
    phase_d    = phase_q;
    run_d      = run_q;
    push_o     = 1'b0;
    job_o.black = 1'b1;
    job_o.face = in_data_i.face_code;
    job_o.lin  = (phase_q < PEAK_PH) ? phase_q[LIN_W-1:0] : phase_dn[LIN_W-1:0];

    if (accept) begin
      if (!run_eff) begin
        push_o = 1'b1;
      end else begin
        run_d = 1'b1;
        if (!pass) begin
          pre_d = pre_inc;
        end else begin
          pre_d       = '0;
          push_o      = 1'b1;
          job_o.black = 1'b0;
          phase_d     = wrap ? '0 : phase_inc;
          if (wrap && !in_data_i.playing) begin
            run_d = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q   <= '0;
      phase_q <= '0;
      run_q   <= 1'b0;
    end else begin
      pre_q   <= pre_d;
      phase_q <= phase_d;
      run_q   <= run_d;
    end
  end

endmodule

// ===== rtl/rbld_fifo.sv =====
// ----------------------------------------------------------------------------
// rbld_fifo
// Two-entry job queue between the tick front end and the fade engine.
// ----------------------------------------------------------------------------
module rbld_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rbld_pkg::rbld_job_t push_data_i,
  input  logic                pop_i,
  output rbld_pkg::rbld_job_t pop_data_o,
  output logic                full_o,
  output logic                empty_o
);
  import rbld_pkg::*;

  rbld_job_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o     = count_q == 2'd2;
  assign empty_o    = count_q == 2'd0;
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & ~empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/rbld_div.sv =====
// ----------------------------------------------------------------------------
// rbld_div
// Restoring divider, 32-bit dividend by 16-bit divisor, two quotient bits
// per cycle. Done stays high until the next start.
// ----------------------------------------------------------------------------
module rbld_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [rbld_pkg::DIV_NUM_W-1:0] dividend_i,
  input  logic [rbld_pkg::DIV_DEN_W-1:0] divisor_i,
  output logic                           done_o,
  output logic [rbld_pkg::DIV_NUM_W-1:0] quotient_o
);
  import rbld_pkg::*;

  localparam int unsigned STEPS  = DIV_NUM_W / 2;
  localparam int unsigned CNT_W  = $clog2(STEPS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

  logic [DIV_NUM_W-1:0] num_q, num_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d, den_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 busy_q, done_q;

  always_comb begin
    logic [DIV_DEN_W:0] trial;
    num_d = num_q;
    rem_d = rem_q;
    for (int k = 0; k < 2; k++) begin
      trial = {rem_d, num_d[DIV_NUM_W-1]};
      num_d = {num_d[DIV_NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        trial    = trial - {1'b0, den_q};
        num_d[0] = 1'b1;
      end
      rem_d = trial[DIV_DEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = num_q;

endmodule

// ===== rtl/rbld_back.sv =====
// ----------------------------------------------------------------------------
// rbld_back
// Fade engine: squares the triangle level, scales it to the full-scale
// value, then scales the face color channels in three divider lanes.
// ----------------------------------------------------------------------------
module rbld_back #(
  parameter int unsigned PEAK_LEVEL = 255
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rbld_pkg::rbld_job_t        job_i,
  input  logic                       q_empty_i,
  output logic                       pop_o,
  input  logic [rbld_pkg::REG_W-1:0] max_brightness_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output rbld_pkg::rbld_out_t        out_data_o
);
  import rbld_pkg::*;

  // normalization by the squared peak is a multiply by a 33-bit reciprocal,
  // done as a low half, then a high half; exact for 32-bit dividends
  localparam int unsigned FACT_W  = SQ_W + REG_W;
  localparam int unsigned PEAK_SQ = PEAK_LEVEL * PEAK_LEVEL;
  localparam int unsigned RCP_L   = $clog2(PEAK_SQ);
  localparam logic [63:0] RCP     =
    ((64'd1 << (FACT_W + RCP_L)) + 64'(PEAK_SQ) - 64'd1) / 64'(PEAK_SQ);
  localparam logic [15:0] RCP_LO  = RCP[15:0];
  localparam logic [16:0] RCP_HI  = RCP[32:16];
  localparam int unsigned FACT_SH = 16 + RCP_L;

  typedef struct packed {
    logic pop;
    logic ch_start;
    logic load_fact;
    logic load_black;
    logic load_levels;
    logic out_load;
  } ctrl_t;

  rbld_state_e state_q, state_d;
  ctrl_t       ctrl;

  logic [LIN_W-1:0]     lin_q;
  logic [3:0]           face_q;
  logic [SQ_W-1:0]      sq_q;
  logic [FACT_W-1:0]    fact_num_q;
  logic [FACT_W+15:0]   fact_lo_q;
  logic [FACT_W+17:0]   fact_sum;
  logic [REG_W-1:0]     factor_q;
  logic [7:0]           lvl_q [NUM_LANES];
  logic                 out_valid_q;
  rbld_out_t            out_q;
  logic                 out_free, mb_zero;
  logic [23:0]          rgb;
  logic [DIV_NUM_W-1:0] quot [NUM_LANES];
  logic [NUM_LANES-1:0] done;

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign mb_zero  = max_brightness_i == '0;
  assign rgb      = base_color(face_q);
  assign fact_sum = fact_num_q * RCP_HI + fact_lo_q[FACT_W+15:16];

  for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
    logic [7:0]           base;
    logic [23:0]          prod;
    logic [DIV_NUM_W-1:0] num;

    assign base = rgb[23-8*c -: 8];
    assign prod = base * factor_q;
    assign num  = {8'd0, prod};

    rbld_div u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (ctrl.ch_start),
      .dividend_i (num),
      .divisor_i  (max_brightness_i),
      .done_o     (done[c]),
      .quotient_o (quot[c])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          state_d = job_i.black ? S_DONE : S_SQUARE;
        end
      end
      S_SQUARE:   state_d = S_SCALE;
      S_SCALE:    state_d = S_FACT_LO;
      S_FACT_LO:  state_d = S_FACT_HI;
      S_FACT_HI:  state_d = S_CH_START;
      S_CH_START: state_d = mb_zero ? S_DONE : S_CH_DIV;
      S_CH_DIV: begin
        if (done[0]) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default:    state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl = '0;
    case (state_q)
      S_IDLE: begin
        ctrl.pop        = ~q_empty_i;
        ctrl.load_black = ~q_empty_i;
      end
      S_FACT_HI:  ctrl.load_fact = 1'b1;
      S_CH_START: begin
        // zero full scale means zero factor and black output
        ctrl.ch_start   = ~mb_zero;
        ctrl.load_black = mb_zero;
      end
      S_CH_DIV:   ctrl.load_levels = done[0];
      S_DONE:     ctrl.out_load = out_free;
      default:    ctrl = '0;
    endcase
  end

  assign pop_o = ctrl.pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctrl.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.pop) begin
      lin_q  <= job_i.lin;
      face_q <= job_i.face;
    end
    if (state_q == S_SQUARE) begin
      sq_q <= lin_q * lin_q;
    end
    if (state_q == S_SCALE) begin
      fact_num_q <= sq_q * max_brightness_i;
    end
    if (state_q == S_FACT_LO) begin
      fact_lo_q <= fact_num_q * RCP_LO;
    end
    if (ctrl.load_fact) begin
      factor_q <= fact_sum[FACT_SH +: REG_W];
    end
    for (int c = 0; c < NUM_LANES; c++) begin
      if (ctrl.load_black) begin
        lvl_q[c] <= '0;
      end else if (ctrl.load_levels) begin
        lvl_q[c] <= quot[c][7:0];
      end
    end
    if (ctrl.out_load) begin
      out_q.red_level   <= lvl_q[0];
      out_q.green_level <= lvl_q[1];
      out_q.blue_level  <= lvl_q[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/rgb_breathing_led_driver_unit.sv =====
// ----------------------------------------------------------------------------
// rgb_breathing_led_driver_unit
// Breathing RGB LED driver with a quadratic fade and face-dependent color.
// ----------------------------------------------------------------------------
//  port group     direction  transfer when
//  in_*           in         in_valid_i & ~in_stall_o  (one tick)
//  out_*          out        out_valid_o & ~out_stall_i (one RGB result)
//  APB            in         psel & penable & pwrite (pready tied high)
//
//  A tick that yields no result queues no job. A black result goes from
//  the job queue through S_DONE to the output register; a fade result's
//  time is set mostly by one pass of the radix-4 divider (channel scale)
//  after a reciprocal multiply for the normalization.
//  Ticks are taken while the two-entry job queue has room; a stalled output
//  holds the result register while the engine works on the next job.
//  Reset clears the running mark, prescaler, phase and registers to defaults.
// ----------------------------------------------------------------------------
module rgb_breathing_led_driver_unit #(
  parameter int unsigned PEAK_LEVEL = 255
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  rbld_pkg::rbld_in_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output rbld_pkg::rbld_out_t             out_data_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rbld_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rbld_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rbld_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import rbld_pkg::*;

  logic [REG_W-1:0] speed_q, maxb_q;
  logic             wr_en, reg_idx;
  logic             q_full, q_empty, push, pop;
  rbld_job_t        push_job, pop_job;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= SPEED_DIVIDER_RST;
      maxb_q  <= MAX_BRIGHTNESS_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SPEED_DIVIDER:  speed_q <= pwdata[REG_W-1:0];
        REG_MAX_BRIGHTNESS: maxb_q  <= pwdata[REG_W-1:0];
        default:            speed_q <= speed_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SPEED_DIVIDER:  prdata = {16'd0, speed_q};
      REG_MAX_BRIGHTNESS: prdata = {16'd0, maxb_q};
      default:            prdata = '0;
    endcase
  end

  rbld_front #(
    .PEAK_LEVEL (PEAK_LEVEL)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_data_i       (in_data_i),
    .speed_divider_i (speed_q),
    .q_full_i        (q_full),
    .in_stall_o      (in_stall_o),
    .push_o          (push),
    .job_o           (push_job)
  );

  rbld_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  rbld_back #(
    .PEAK_LEVEL (PEAK_LEVEL)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_i            (pop_job),
    .q_empty_i        (q_empty),
    .pop_o            (pop),
    .max_brightness_i (maxb_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_data_o       (out_data_o)
  );

endmodule

// ===== tb/tb_rgb_breathing_led_driver_unit.sv =====
// ----------------------------------------------------------------------------
// tb_rgb_breathing_led_driver_unit
// Self-checking bench for the breathing RGB LED driver. Ticks go in over a
// valid/stall channel, and each accepted tick is run through a local fade
// predictor (running mark, prescaler, triangle phase, quadratic scaling).
// Every RGB result that comes out is checked field by field, in order,
// against the oldest prediction. Directed tests cover black output, every
// face code, register extremes, a lowered divider, a full breath and an
// output hold; random phases with random stalls and gaps follow.
// ----------------------------------------------------------------------------
module tb_rgb_breathing_led_driver_unit;
  import rbld_pkg::*;

  localparam int unsigned PEAK      = 255;
  localparam int unsigned IDLE_WAIT = 60;

  // base colors {red, green, blue} for faces 0..9
  localparam logic [23:0] FACE_RGB [10] = '{
    {8'd255, 8'd200, 8'd0},   {8'd50,  8'd255, 8'd50},  {8'd0,  8'd200, 8'd200},
    {8'd255, 8'd255, 8'd255}, {8'd100, 8'd100, 8'd100}, {8'd60, 8'd60,  8'd80},
    {8'd255, 8'd0,   8'd0},   {8'd0,   8'd0,   8'd255}, {8'd40, 8'd0,   8'd80},
    {8'd255, 8'd150, 8'd0}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid;
  logic                  in_stall;
  rbld_in_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  rbld_out_t             out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  rgb_breathing_led_driver_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // predictor state and register copies
  logic [15:0] cfg_speed_div;
  logic [15:0] cfg_max_bright;
  logic [15:0] fade_prescale;
  logic [8:0]  fade_phase;
  logic        fade_running;

  rbld_out_t   expected_rgb_q[$];
  int unsigned fail_count;
  int unsigned hold_left;     // long receiver hold-off, set by a test
  bit          quiet;         // no idling on either side
  bit          tx_gaps_en;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // One tick through the fade: returns whether a result is emitted.
  function automatic bit predict_tick(input rbld_in_t tick, output rbld_out_t rgb);
    int unsigned       lin;
    longint unsigned   factor;
    logic [23:0]       base;
    rgb = '0;
    if (tick.playing) fade_running = 1'b1;
    if (!fade_running) return 1'b1;
    fade_prescale = fade_prescale + 16'd1;
    if (fade_prescale < cfg_speed_div) return 1'b0;
    fade_prescale = '0;
    lin    = (fade_phase < PEAK) ? fade_phase : 2 * PEAK - fade_phase;
    factor = longint'(lin) * lin * cfg_max_bright / (PEAK * PEAK);
    base   = (tick.face_code < NUM_FACES) ? FACE_RGB[tick.face_code] : 24'd0;
    if (cfg_max_bright != 0) begin
      rgb.red_level   = 8'(longint'(base[23:16]) * factor / cfg_max_bright);
      rgb.green_level = 8'(longint'(base[15:8]) * factor / cfg_max_bright);
      rgb.blue_level  = 8'(longint'(base[7:0]) * factor / cfg_max_bright);
    end
    fade_phase = fade_phase + 9'd1;
    if (fade_phase >= 2 * PEAK) begin
      fade_phase = '0;
      if (!tick.playing) fade_running = 1'b0;
    end
    return 1'b1;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer,
  // leaving valid high so the next tick can follow back to back.
  task automatic send_tick(input logic playing, input logic [3:0] face);
    rbld_out_t rgb;
    if (!quiet && tx_gaps_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    in_valid          <= 1'b1;
    in_data.playing   <= playing;
    in_data.face_code <= face;
    do @(posedge clk_i); while (in_stall);
    if (predict_tick(in_data, rgb)) expected_rgb_q.push_back(rgb);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_rgb_q.size() != 0) @(negedge clk_i);
    repeat (IDLE_WAIT) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic reg_sel, input logic [15:0] value);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= {16'd0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (reg_sel == REG_SPEED_DIVIDER) cfg_speed_div = value;
    else cfg_max_bright = value;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // result checker
  always @(posedge clk_i) begin : rgb_check
    rbld_out_t exp_rgb;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_rgb_q.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, out_data);
        fail_count++;
      end else begin
        exp_rgb = expected_rgb_q.pop_front();
        if (out_data.red_level !== exp_rgb.red_level) begin
          $display("%0t: red_level expected %0d actual %0d", $time,
                   exp_rgb.red_level, out_data.red_level);
          fail_count++;
        end
        if (out_data.green_level !== exp_rgb.green_level) begin
          $display("%0t: green_level expected %0d actual %0d", $time,
                   exp_rgb.green_level, out_data.green_level);
          fail_count++;
        end
        if (out_data.blue_level !== exp_rgb.blue_level) begin
          $display("%0t: blue_level expected %0d actual %0d", $time,
                   exp_rgb.blue_level, out_data.blue_level);
          fail_count++;
        end
      end
    end
  end

  // receiver stall: random bursts, stretches without any, and long hold-offs
  always begin : rx_stall_gen
    int unsigned burst_left;
    int unsigned cyc;
    bit          bursts_en;
    burst_left = 0;
    cyc        = 0;
    bursts_en  = 1'b1;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc % 256 == 0) bursts_en = ($urandom_range(0, 2) != 0);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (burst_left > 0) begin
        out_stall <= 1'b1;
        burst_left--;
      end else if (!quiet && bursts_en && $urandom_range(0, 5) == 0) begin
        out_stall  <= 1'b1;
        burst_left = $urandom_range(0, 16);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // not running: every tick gives black, including unknown faces
  task automatic test_stopped_black();
    send_tick(1'b0, 4'd0);
    send_tick(1'b0, 4'd3);
    send_tick(1'b0, 4'd9);
    send_tick(1'b0, 4'd15);
  endtask

  // every face code, known and unknown, at the start of a breath
  task automatic test_every_face();
    for (int f = 0; f < 16; f++) send_tick(1'b1, 4'(f));
  endtask

  // divider at its top, then lowered mid-count: the next tick passes
  task automatic test_divider_lowered();
    write_reg(REG_SPEED_DIVIDER, 16'hFFFF);
    send_tick(1'b1, 4'd3);
    send_tick(1'b1, 4'd3);
    send_tick(1'b1, 4'd3);
    write_reg(REG_SPEED_DIVIDER, 16'd2);
    send_tick(1'b1, 4'd3);
    send_tick(1'b1, 4'd3);
  endtask

  // zero full scale gives black; then the largest full scale
  task automatic test_brightness_extremes();
    write_reg(REG_SPEED_DIVIDER, 16'd0);
    write_reg(REG_MAX_BRIGHTNESS, 16'd0);
    send_tick(1'b1, 4'd3);
    send_tick(1'b1, 4'd0);
    write_reg(REG_MAX_BRIGHTNESS, 16'hFFFF);
    send_tick(1'b1, 4'd3);
    send_tick(1'b1, 4'd6);
  endtask

  // a whole breath through the peak, then playing drops and the mark clears
  task automatic test_full_breath();
    write_reg(REG_MAX_BRIGHTNESS, 16'd255);
    for (int i = 0; i < 560; i++)
      send_tick(i < 380, 4'($urandom_range(0, 15)));
  endtask

  // receiver holds off while ticks keep coming, so the job queue fills
  task automatic test_output_hold();
    write_reg(REG_SPEED_DIVIDER, 16'd1);
    hold_left = 300;
    for (int i = 0; i < 30; i++) send_tick(1'b1, 4'($urandom_range(0, 9)));
  endtask

  task automatic test_random_phases(input int unsigned n_items);
    int unsigned sent;
    int unsigned n_phase;
    bit          noisy;
    logic [15:0] div_val;
    logic [15:0] bright_val;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 5))
        0:       div_val = 16'd0;
        1:       div_val = 16'd2;
        2:       div_val = 16'($urandom_range(3, 6));
        3:       div_val = 16'($urandom_range(7, 20));
        default: div_val = 16'd1;
      endcase
      case ($urandom_range(0, 6))
        0:       bright_val = 16'd0;
        1:       bright_val = 16'd1;
        2:       bright_val = 16'hFFFF;
        3:       bright_val = 16'($urandom_range(1, 65535));
        4:       bright_val = 16'($urandom_range(100, 400));
        default: bright_val = 16'd255;
      endcase
      if (sent + 250 >= n_items) quiet = 1'b1;
      write_reg(REG_SPEED_DIVIDER, div_val);
      write_reg(REG_MAX_BRIGHTNESS, bright_val);
      tx_gaps_en = ($urandom_range(0, 2) != 0);
      noisy      = ($urandom_range(0, 4) == 0);
      n_phase    = $urandom_range(80, 200);
      for (int i = 0; i < n_phase; i++) begin
        if (noisy) send_tick(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
        else send_tick($urandom_range(0, 9) != 0, 4'($urandom_range(0, 15)));
      end
      sent += n_phase;
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    cfg_speed_div  = 16'd1;
    cfg_max_bright = 16'd255;
    fade_prescale  = '0;
    fade_phase     = '0;
    fade_running   = 1'b0;
    fail_count     = 0;
    hold_left      = 0;
    quiet          = 1'b0;
    tx_gaps_en     = 1'b1;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_stopped_black();
    test_every_face();
    test_divider_lowered();
    test_brightness_extremes();
    test_full_breath();
    test_output_hold();
    test_random_phases(1400);

    wait_idle();
    if (fail_count == 0) begin
      $display("** rgb_breathing_led_driver_unit: PASSED **");
    end else begin
      $display("** rgb_breathing_led_driver_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("** rgb_breathing_led_driver_unit: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rbld_pkg.sv
rtl/rbld_front.sv
rtl/rbld_fifo.sv
rtl/rbld_div.sv
rtl/rbld_back.sv
rtl/rgb_breathing_led_driver_unit.sv
tb/tb_rgb_breathing_led_driver_unit.sv
